[hw/rtl/pmr_pkg.sv]
// Shared types and constants for the pot mouse to relative motion unit.
package pmr_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned PosW     = 7;
  localparam int unsigned SpeedW   = 4;
  localparam int unsigned MoveW    = 8;
  localparam int unsigned ThreshW  = 6;
  localparam int unsigned LimitW   = 3;

  localparam logic              AccelEnableRst    = 1'b0;
  localparam logic [ThreshW-1:0] AccelThresholdRst = 6'd5;
  localparam logic [LimitW-1:0]  JoySpeedLimitRst  = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_ENABLE    = 2'd0,
    CFG_ACCEL_THRESHOLD = 2'd1,
    CFG_JOY_SPEED_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              accel_enable;
    logic [ThreshW-1:0] accel_threshold;
    logic [LimitW-1:0]  joy_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] pot_x_count;
    logic [CountW-1:0] pot_y_count;
    logic              fire_pin;
    logic              up_pin;
    logic              down_pin;
    logic              left_pin;
    logic              right_pin;
    logic              pot_x_level;
  } frame_t;

  typedef struct packed {
    logic                    proportional_mode;
    logic                    move_valid;
    logic signed [MoveW-1:0] move_x;
    logic signed [MoveW-1:0] move_y;
    logic                    left_changed;
    logic                    left_down;
    logic                    right_changed;
    logic                    right_down;
  } result_t;

  typedef struct packed {
    logic [PosW-1:0]          last_pos_x;
    logic [PosW-1:0]          last_pos_y;
    logic signed [SpeedW-1:0] joy_speed_x;
    logic signed [SpeedW-1:0] joy_speed_y;
    logic                     left_last;
    logic                     right_last;
  } state_t;

endpackage

[hw/rtl/pmr_in_if.sv]
// Input channel carrying one measurement frame per item.
interface pmr_in_if
  import pmr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] pot_x_count;
  logic [CountW-1:0] pot_y_count;
  logic              fire_pin;
  logic              up_pin;
  logic              down_pin;
  logic              left_pin;
  logic              right_pin;
  logic              pot_x_level;

  modport source (output valid, pot_x_count, pot_y_count, fire_pin, up_pin, down_pin,
                  left_pin, right_pin, pot_x_level, input ready);
  modport sink (input valid, pot_x_count, pot_y_count, fire_pin, up_pin, down_pin,
                left_pin, right_pin, pot_x_level, output ready);
endinterface

[hw/rtl/pmr_out_if.sv]
// Result channel carrying one motion and button report per item.
interface pmr_out_if
  import pmr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    proportional_mode;
  logic                    move_valid;
  logic signed [MoveW-1:0] move_x;
  logic signed [MoveW-1:0] move_y;
  logic                    left_changed;
  logic                    left_down;
  logic                    right_changed;
  logic                    right_down;

  modport source (output valid, proportional_mode, move_valid, move_x, move_y,
                  left_changed, left_down, right_changed, right_down, input ready);
  modport sink (input valid, proportional_mode, move_valid, move_x, move_y,
                left_changed, left_down, right_changed, right_down, output ready);
endinterface

[hw/rtl/pmr_cfg_if.sv]
// Configuration write channel with register index and write data.
interface pmr_cfg_if
  import pmr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/pmr_decode.sv]
// Combinational frame decoder: motion, buttons and next tracking state.
module pmr_decode
  import pmr_pkg::*;
(
  input  frame_t  frame,
  input  cfg_t    cfg,
  input  state_t  state,
  output result_t result,
  output state_t  state_nxt
);

  function automatic logic signed [SpeedW-1:0] joy_axis(
    input logic signed [SpeedW-1:0] speed,
    input logic                     dir_neg,
    input logic                     dir_pos,
    input logic [LimitW-1:0]        lim
  );
    logic signed [SpeedW:0] s;
    logic signed [SpeedW:0] lim_p;
    logic signed [SpeedW:0] lim_n;
    s     = {speed[SpeedW-1], speed};
    lim_p = signed'({{(SpeedW+1-LimitW){1'b0}}, lim});
    lim_n = -lim_p;
    if (dir_pos) begin
      s = s + 5'sd1;
    end else if (dir_neg) begin
      s = s - 5'sd1;
    end else if (s < 0) begin
      s = s + 5'sd1;
    end else if (s > 0) begin
      s = s - 5'sd1;
    end
    if (s > lim_p) begin
      s = lim_p;
    end
    if (s < lim_n) begin
      s = lim_n;
    end
    return s[SpeedW-1:0];
  endfunction

  logic                   prop;
  logic [PosW-1:0]        cx;
  logic [PosW-1:0]        cy;
  logic [PosW-1:0]        dx;
  logic [PosW-1:0]        dy;
  logic [PosW-1:0]        mag_x;
  logic [PosW-1:0]        mag_y;
  logic                   dbl;
  logic signed [MoveW-1:0] pmx;
  logic signed [MoveW-1:0] pmy;
  logic signed [SpeedW-1:0] jsx;
  logic signed [SpeedW-1:0] jsy;
  logic signed [MoveW-1:0] mx;
  logic signed [MoveW-1:0] my;
  logic                   ldown;
  logic                   rdown;

  always_comb begin
    prop  = (frame.pot_x_count != '0) && (frame.pot_y_count != '0);
    cx    = frame.pot_x_count[PosW-1:0];
    cy    = frame.pot_y_count[PosW-1:0];
    dx    = cx - state.last_pos_x;
    dy    = state.last_pos_y - cy;
    mag_x = dx[PosW-1] ? -dx : dx;
    mag_y = dy[PosW-1] ? -dy : dy;
    dbl   = cfg.accel_enable &&
            ((mag_x > {1'b0, cfg.accel_threshold}) || (mag_y > {1'b0, cfg.accel_threshold}));
    pmx   = dbl ? {dx, 1'b0} : {dx[PosW-1], dx};
    pmy   = dbl ? {dy, 1'b0} : {dy[PosW-1], dy};

    // Right wins over left and down wins over up when both are held.
    jsx = joy_axis(state.joy_speed_x, !frame.left_pin && frame.right_pin, !frame.right_pin,
                   cfg.joy_speed_limit);
    jsy = joy_axis(state.joy_speed_y, !frame.up_pin && frame.down_pin, !frame.down_pin,
                   cfg.joy_speed_limit);

    state_nxt = state;
    if (prop) begin
      mx                   = pmx;
      my                   = pmy;
      rdown                = !frame.up_pin;
      state_nxt.last_pos_x = cx;
      state_nxt.last_pos_y = cy;
    end else begin
      mx                    = MoveW'(jsx);
      my                    = MoveW'(jsy);
      rdown                 = !frame.pot_x_level;
      state_nxt.joy_speed_x = jsx;
      state_nxt.joy_speed_y = jsy;
    end
    ldown                = !frame.fire_pin;
    state_nxt.left_last  = ldown;
    state_nxt.right_last = rdown;

    result.proportional_mode = prop;
    result.move_valid        = (mx != '0) || (my != '0);
    result.move_x            = mx;
    result.move_y            = my;
    result.left_changed      = ldown != state.left_last;
    result.left_down         = ldown;
    result.right_changed     = rdown != state.right_last;
    result.right_down        = rdown;
  end

endmodule

[hw/rtl/pot_mouse_to_relative_motion_unit.sv]
// Top level of the pot mouse to relative motion unit.
//
//   channel  direction  handshake          content
//   in_ch    sink       valid / ready      one measurement frame
//   out_ch   source     valid / ready      motion and button report
//   cfg_ch   sink       valid / ready=1    register index and write data
//
// Each item passes an input register and a result register. Unless out_ch is stalled,
// one item is accepted per cycle; the result register holds while out_ch is stalled.
// Tracking state updates as an item moves from the input to the result register.
// Synchronous reset restores the register defaults and the tracking state.
module pot_mouse_to_relative_motion_unit
  import pmr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  pmr_in_if.sink   in_ch,
  pmr_out_if.source out_ch,
  pmr_cfg_if.sink  cfg_ch
);

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  logic    in_valid_r;
  frame_t  in_frame_r;
  logic    out_valid_r;
  result_t out_res_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  frame_t  frame;
  logic    advance;
  logic    in_take;

  assign frame = '{
    pot_x_count: in_ch.pot_x_count,
    pot_y_count: in_ch.pot_y_count,
    fire_pin:    in_ch.fire_pin,
    up_pin:      in_ch.up_pin,
    down_pin:    in_ch.down_pin,
    left_pin:    in_ch.left_pin,
    right_pin:   in_ch.right_pin,
    pot_x_level: in_ch.pot_x_level
  };

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ACCEL_ENABLE:    cfg_nxt.accel_enable    = cfg_ch.data[0];
        CFG_ACCEL_THRESHOLD: cfg_nxt.accel_threshold = cfg_ch.data[ThreshW-1:0];
        CFG_JOY_SPEED_LIMIT: cfg_nxt.joy_speed_limit = cfg_ch.data[LimitW-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  pmr_decode u_decode (
    .frame     (in_frame_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .result    (res),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_enable    <= AccelEnableRst;
      cfg_r.accel_threshold <= AccelThresholdRst;
      cfg_r.joy_speed_limit <= JoySpeedLimitRst;
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.last_pos_x    <= '0;
      state_r.last_pos_y    <= '0;
      state_r.joy_speed_x   <= '0;
      state_r.joy_speed_y   <= '0;
      state_r.left_last     <= 1'b1;
      state_r.right_last    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_frame_r <= frame;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.proportional_mode = out_res_r.proportional_mode;
  assign out_ch.move_valid        = out_res_r.move_valid;
  assign out_ch.move_x            = out_res_r.move_x;
  assign out_ch.move_y            = out_res_r.move_y;
  assign out_ch.left_changed      = out_res_r.left_changed;
  assign out_ch.left_down         = out_res_r.left_down;
  assign out_ch.right_changed     = out_res_r.right_changed;
  assign out_ch.right_down        = out_res_r.right_down;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.joy_speed_x != -4'sd8) && (state_r.joy_speed_y != -4'sd8))
    else $error("joystick speed outside the limit range");

  a_state_held_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("tracking state changed without an item");

  a_move_valid_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.move_valid ==
                     ((out_res_r.move_x != '0) || (out_res_r.move_y != '0))))
    else $error("move_valid disagrees with motion values");

endmodule
